>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset.
`define ASSERT_CLK_NORST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/dtsl_pkg.sv
// Package with types, constants and calendar helpers for the date/time setter.
package dtsl_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int OP_W     = 4;
    localparam int YQ_W     = 8;
    localparam int YR_W     = 7;

    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [YEAR_W-1:0]  HUNDRED   = 14'd100;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YQ_W-1:0]    YQ_TOP     = 8'd99;
    localparam logic [YR_W-1:0]    YR_TOP     = 7'd99;
    localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;
    localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX    = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX    = 6'd59;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [OP_W-1:0] {
        OP_YEAR_UP  = 4'd0,
        OP_YEAR_DN  = 4'd1,
        OP_MONTH_UP = 4'd2,
        OP_MONTH_DN = 4'd3,
        OP_DAY_UP   = 4'd4,
        OP_DAY_DN   = 4'd5,
        OP_HOUR_UP  = 4'd6,
        OP_HOUR_DN  = 4'd7,
        OP_MIN_UP   = 4'd8,
        OP_MIN_DN   = 4'd9,
        OP_SEC_UP   = 4'd10,
        OP_SEC_DN   = 4'd11,
        OP_LOAD     = 4'd12
    } t_op;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [YQ_W-1:0]    yq;
        logic [YR_W-1:0]    yr;
    } t_cal;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [YQ_W-1:0]    yq;
    } t_item;

    localparam t_cal CAL_RESET = '{
        year:   14'd2000,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0,
        yq:     8'd20,
        yr:     7'd0
    };

    // Year kept as hundreds and remainder; year mod 4 equals remainder mod 4.
    function automatic logic leap_of(input logic [YQ_W-1:0] q, input logic [YR_W-1:0] r);
        logic leap;
        if (r == '0) begin
            leap = (q[1:0] == 2'd0);
        end else begin
            leap = (r[1:0] == 2'd0);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0]   len;
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_FIRST;
        if (m == '0 || m > MONTH_MAX) begin
            len = DAYS_LONG;
        end else if (m == MONTH_FEB) begin
            len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end else begin
            len = MONTH_LEN[idx];
        end
        return len;
    endfunction

endpackage

>>> hdl/dtsl_update.sv
// Next calendar state for one item: load, field press and February clamp.
module dtsl_update (
    input  dtsl_pkg::t_item i_item,
    input  dtsl_pkg::t_cal  i_cur,
    output dtsl_pkg::t_cal  o_next
);
    import dtsl_pkg::*;

    t_cal              nxt;
    logic              cur_leap;
    logic              nxt_leap;
    logic              is_press;
    logic [DAY_W-1:0]  day_len;
    logic [DAY_W-1:0]  feb_lim;
    logic [YEAR_W-1:0] load_rem;

    assign load_rem = i_item.year - YEAR_W'(YEAR_W'(i_item.yq) * HUNDRED);

    always_comb begin
        cur_leap = leap_of(i_cur.yq, i_cur.yr);
        day_len  = days_in_month(i_cur.month, cur_leap);
        is_press = (i_item.op < OP_LOAD);
        nxt      = i_cur;

        unique case (i_item.op)
            OP_LOAD: begin
                nxt.year   = i_item.year;
                nxt.month  = i_item.month;
                nxt.day    = i_item.day;
                nxt.hour   = i_item.hour;
                nxt.minute = i_item.minute;
                nxt.second = i_item.second;
                nxt.yq     = i_item.yq;
                nxt.yr     = load_rem[YR_W-1:0];
            end
            OP_YEAR_UP: begin
                if (i_cur.year >= YEAR_MAX) begin
                    nxt.year = YEAR_MAX;
                    nxt.yq   = YQ_TOP;
                    nxt.yr   = YR_TOP;
                end else begin
                    nxt.year = i_cur.year + 1'b1;
                    if (i_cur.yr == YR_TOP) begin
                        nxt.yr = '0;
                        nxt.yq = i_cur.yq + 1'b1;
                    end else begin
                        nxt.yr = i_cur.yr + 1'b1;
                    end
                end
            end
            OP_YEAR_DN: begin
                if (i_cur.year > YEAR_MAX) begin
                    nxt.year = YEAR_MAX;
                    nxt.yq   = YQ_TOP;
                    nxt.yr   = YR_TOP;
                end else if (i_cur.year != '0) begin
                    nxt.year = i_cur.year - 1'b1;
                    if (i_cur.yr == '0) begin
                        nxt.yr = YR_TOP;
                        nxt.yq = i_cur.yq - 1'b1;
                    end else begin
                        nxt.yr = i_cur.yr - 1'b1;
                    end
                end
            end
            OP_MONTH_UP: begin
                nxt.month = (i_cur.month >= MONTH_MAX) ? MONTH_FIRST : i_cur.month + 1'b1;
            end
            OP_MONTH_DN: begin
                nxt.month = (i_cur.month <= MONTH_FIRST || i_cur.month > MONTH_MAX)
                          ? MONTH_MAX : i_cur.month - 1'b1;
            end
            OP_DAY_UP: begin
                nxt.day = (i_cur.day >= day_len) ? DAY_FIRST : i_cur.day + 1'b1;
            end
            OP_DAY_DN: begin
                nxt.day = (i_cur.day <= DAY_FIRST) ? day_len : i_cur.day - 1'b1;
            end
            OP_HOUR_UP: begin
                nxt.hour = (i_cur.hour >= HOUR_MAX) ? '0 : i_cur.hour + 1'b1;
            end
            OP_HOUR_DN: begin
                nxt.hour = (i_cur.hour == '0 || i_cur.hour > HOUR_MAX)
                         ? HOUR_MAX : i_cur.hour - 1'b1;
            end
            OP_MIN_UP: begin
                nxt.minute = (i_cur.minute >= MIN_MAX) ? '0 : i_cur.minute + 1'b1;
            end
            OP_MIN_DN: begin
                nxt.minute = (i_cur.minute == '0 || i_cur.minute > MIN_MAX)
                           ? MIN_MAX : i_cur.minute - 1'b1;
            end
            OP_SEC_UP: begin
                nxt.second = (i_cur.second >= SEC_MAX) ? '0 : i_cur.second + 1'b1;
            end
            OP_SEC_DN: begin
                nxt.second = (i_cur.second == '0 || i_cur.second > SEC_MAX)
                           ? SEC_MAX : i_cur.second - 1'b1;
            end
            default: begin
            end
        endcase

        // clamp February day after any press
        nxt_leap = leap_of(nxt.yq, nxt.yr);
        feb_lim  = nxt_leap ? DAYS_FEB_LEAP : DAYS_FEB;
        if (is_press && nxt.month == MONTH_FEB && nxt.day > feb_lim) begin
            nxt.day = feb_lim;
        end
        o_next = nxt;
    end

endmodule

>>> hdl/date_time_setter_leap_year.sv
// Top level of the calendar date/time setter with leap-year handling.
//
// Input channel i_valid/o_ready carries one item: an operation code and six
// load values. Codes 0..11 press one field up (even) or down (odd); code 12
// loads all six fields unchecked; codes 13..15 leave the state unchanged.
// Output channel o_valid/i_ready carries one result per item: the six fields
// after that item.
// From acceptance to o_valid an item passes one input register that also holds
// the load year split into hundreds, then the state register, which is the
// result register. Throughput is one item per cycle while the receiver does not
// stall, set by the single state update path.
// A stalled receiver holds the result on the outputs; one more item waits in
// the input register, and o_ready drops only when both are full.
// Reset sets 2000-01-01 00:00:00 and empties both registers.
module date_time_setter_leap_year (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dtsl_pkg::OP_W-1:0]     i_operation,
    input  logic [dtsl_pkg::YEAR_W-1:0]   i_load_year,
    input  logic [dtsl_pkg::MONTH_W-1:0]  i_load_month,
    input  logic [dtsl_pkg::DAY_W-1:0]    i_load_day,
    input  logic [dtsl_pkg::HOUR_W-1:0]   i_load_hour,
    input  logic [dtsl_pkg::MIN_W-1:0]    i_load_minute,
    input  logic [dtsl_pkg::SEC_W-1:0]    i_load_second,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dtsl_pkg::YEAR_W-1:0]   o_year,
    output logic [dtsl_pkg::MONTH_W-1:0]  o_month,
    output logic [dtsl_pkg::DAY_W-1:0]    o_day,
    output logic [dtsl_pkg::HOUR_W-1:0]   o_hour,
    output logic [dtsl_pkg::MIN_W-1:0]    o_minute,
    output logic [dtsl_pkg::SEC_W-1:0]    o_second
);
    import dtsl_pkg::*;

    logic              r_in_valid;
    t_item             r_item;
    t_item             n_item;
    logic              r_out_valid;
    t_cal              r_cal;
    t_cal              n_cal;
    logic              advance;
    logic [PROD_W-1:0] year_prod;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    assign year_prod = PROD_W'(i_load_year) * PROD_W'(RECIP_100);

    always_comb begin
        n_item.op     = i_operation;
        n_item.year   = i_load_year;
        n_item.month  = i_load_month;
        n_item.day    = i_load_day;
        n_item.hour   = i_load_hour;
        n_item.minute = i_load_minute;
        n_item.second = i_load_second;
        n_item.yq     = year_prod[RECIP_SHIFT +: YQ_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    dtsl_update u_update (
        .i_item (r_item),
        .i_cur  (r_cal),
        .o_next (n_cal)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cal       <= CAL_RESET;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_cal <= n_cal;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_year   = r_cal.year;
    assign o_month  = r_cal.month;
    assign o_day    = r_cal.day;
    assign o_hour   = r_cal.hour;
    assign o_minute = r_cal.minute;
    assign o_second = r_cal.second;

endmodule

>>> hdl/dtsl_checker.sv
// Port checker for the date/time setter and its bind to the top level.
`include "assert_macros.svh"

module dtsl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [dtsl_pkg::YEAR_W-1:0]   o_year,
    input logic [dtsl_pkg::MONTH_W-1:0]  o_month,
    input logic [dtsl_pkg::DAY_W-1:0]    o_day,
    input logic [dtsl_pkg::HOUR_W-1:0]   o_hour,
    input logic [dtsl_pkg::MIN_W-1:0]    o_minute,
    input logic [dtsl_pkg::SEC_W-1:0]    o_second
);

    `ASSERT_CLK_NORST(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid, "o_valid after reset")

    `ASSERT_CLK(a_out_held, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "item dropped")

    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_year) && $stable(o_month) && $stable(o_day) && $stable(o_hour) && $stable(o_minute) && $stable(o_second), "result changed while stalled")

    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "input blocked with empty output")

    `ASSERT_CLK(a_item_delivered, i_clk, i_rst_n, (i_valid && o_ready) ##1 (!o_valid || i_ready) |=> o_valid, "accepted item gave no result")

endmodule

bind date_time_setter_leap_year dtsl_checker u_dtsl_checker (.*);

>>> verif/date_time_setter_leap_year_tb.sv
// Self-checking testbench for the date/time setter with leap-year handling.
`timescale 1ns / 100ps

module date_time_setter_leap_year_tb;
    import dtsl_pkg::*;

    localparam real         CLK_PERIOD   = 10.0;
    localparam int          RESET_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          CALM_ITEMS   = 150;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          OP_CODES     = 1 << OP_W;
    localparam int unsigned EDGE_YEARS [10] = '{0, 1, 4, 100, 400, 1900, 2000, 2100, 2400, 9999};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cal_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } press_t;

    class calendar_scoreboard;
        cal_t now_cal;
        cal_t predicted_cal[$];
        int   errors;

        function new();
            now_cal = '{year: CAL_RESET.year, month: CAL_RESET.month, day: CAL_RESET.day,
                        hour: CAL_RESET.hour, minute: CAL_RESET.minute,
                        second: CAL_RESET.second};
            errors = 0;
        endfunction

        function int pending();
            return predicted_cal.size();
        endfunction

        function bit leap_year(int unsigned y);
            if (y % 100 == 0) return (y % 400) == 0;
            return (y % 4) == 0;
        endfunction

        function int unsigned month_days(int unsigned m, int unsigned y);
            if (m < MONTH_FIRST || m > MONTH_MAX) return DAYS_LONG;
            if (m == MONTH_FEB) return leap_year(y) ? DAYS_FEB_LEAP : DAYS_FEB;
            return MONTH_LEN[m - 1];
        endfunction

        function int unsigned step_wrap(int unsigned v, int unsigned top, bit up);
            if (up) return (v >= top) ? 0 : v + 1;
            return (v == 0 || v > top) ? top : v - 1;
        endfunction

        function void note_item(press_t it);
            int unsigned y, mo, d, h, mi, s, len;
            bit          up;
            y  = now_cal.year;
            mo = now_cal.month;
            d  = now_cal.day;
            h  = now_cal.hour;
            mi = now_cal.minute;
            s  = now_cal.second;
            up = (it.op[0] == 1'b0);
            if (it.op == OP_LOAD) begin
                y  = it.year;
                mo = it.month;
                d  = it.day;
                h  = it.hour;
                mi = it.minute;
                s  = it.second;
            end else if (it.op < OP_LOAD) begin
                case (it.op)
                    OP_YEAR_UP:  y = (y >= YEAR_MAX) ? YEAR_MAX : y + 1;
                    OP_YEAR_DN:  y = (y > YEAR_MAX) ? YEAR_MAX : ((y > 0) ? y - 1 : 0);
                    OP_MONTH_UP: mo = (mo >= MONTH_MAX) ? MONTH_FIRST : mo + 1;
                    OP_MONTH_DN: begin
                        mo = (mo <= MONTH_FIRST || mo > MONTH_MAX) ? MONTH_MAX : mo - 1;
                    end
                    OP_DAY_UP, OP_DAY_DN: begin
                        len = month_days(mo, y);
                        if (up) d = (d + 1 > len) ? DAY_FIRST : d + 1;
                        else d = (d <= DAY_FIRST) ? len : d - 1;
                    end
                    OP_HOUR_UP, OP_HOUR_DN: h = step_wrap(h, HOUR_MAX, up);
                    OP_MIN_UP, OP_MIN_DN:   mi = step_wrap(mi, MIN_MAX, up);
                    default:                s = step_wrap(s, SEC_MAX, up);
                endcase
                if (mo == MONTH_FEB && d > month_days(mo, y)) d = month_days(mo, y);
            end
            now_cal = '{year: y, month: mo, day: d, hour: h, minute: mi, second: s};
            predicted_cal.push_back(now_cal);
        endfunction

        task report(string msg);
            if (errors < 50) $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(cal_t got);
            cal_t want;
            if (predicted_cal.size() == 0) begin
                report($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with no item pending",
                                 got.year, got.month, got.day, got.hour, got.minute,
                                 got.second));
                return;
            end
            want = predicted_cal.pop_front();
            check_field("year", got.year, want.year);
            check_field("month", got.month, want.month);
            check_field("day", got.day, want.day);
            check_field("hour", got.hour, want.hour);
            check_field("minute", got.minute, want.minute);
            check_field("second", got.second, want.second);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [OP_W-1:0]    i_operation;
    logic [YEAR_W-1:0]  i_load_year;
    logic [MONTH_W-1:0] i_load_month;
    logic [DAY_W-1:0]   i_load_day;
    logic [HOUR_W-1:0]  i_load_hour;
    logic [MIN_W-1:0]   i_load_minute;
    logic [SEC_W-1:0]   i_load_second;
    logic               o_valid;
    logic               i_ready;
    logic [YEAR_W-1:0]  o_year;
    logic [MONTH_W-1:0] o_month;
    logic [DAY_W-1:0]   o_day;
    logic [HOUR_W-1:0]  o_hour;
    logic [MIN_W-1:0]   o_minute;
    logic [SEC_W-1:0]   o_second;

    calendar_scoreboard sb = new();
    int                 cycles = 0;
    int                 gap_odds = 0;
    int                 stall_left = 0;
    bit                 ready_gaps_on = 1'b1;
    bit                 calm_tail = 1'b0;

    date_time_setter_leap_year i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_load_year   (i_load_year),
        .i_load_month  (i_load_month),
        .i_load_day    (i_load_day),
        .i_load_hour   (i_load_hour),
        .i_load_minute (i_load_minute),
        .i_load_second (i_load_second),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_year        (o_year),
        .o_month       (o_month),
        .o_day         (o_day),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(cal_t'{o_year, o_month, o_day, o_hour, o_minute, o_second});
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) ready_gaps_on <= !ready_gaps_on;
        if (calm_tail || !ready_gaps_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_item(input press_t it);
        if (!calm_tail && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= it.op;
        i_load_year   <= it.year;
        i_load_month  <= it.month;
        i_load_day    <= it.day;
        i_load_hour   <= it.hour;
        i_load_minute <= it.minute;
        i_load_second <= it.second;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic press(input logic [OP_W-1:0] op);
        press_t it;
        it        = press_t'($urandom());
        it.op     = op;
        it.year   = $urandom();
        send_item(it);
    endtask

    task automatic load(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] mo,
                        input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
                        input logic [MIN_W-1:0] mi, input logic [SEC_W-1:0] s);
        send_item('{op: OP_LOAD, year: y, month: mo, day: d, hour: h, minute: mi, second: s});
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        press_t it;
        int     n;
        int     run_len;
        int     r;
        bit     wild;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_operation   = OP_LOAD;
        i_load_year   = '0;
        i_load_month  = '0;
        i_load_day    = '0;
        i_load_hour   = '0;
        i_load_minute = '0;
        i_load_second = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int c = OP_LOAD + 1; c < OP_CODES; c++) press(c);
        load('1, '1, '1, '1, '1, '1);
        press(OP_YEAR_DN);
        press(OP_HOUR_DN);
        press(OP_MIN_UP);
        press(OP_SEC_DN);
        press(OP_DAY_UP);
        press(OP_MONTH_UP);
        load('0, '0, '0, '0, '0, '0);
        press(OP_YEAR_DN);
        press(OP_DAY_DN);
        press(OP_MONTH_DN);
        press(OP_HOUR_UP);
        press(OP_MIN_DN);
        press(OP_SEC_UP);
        load(1900, 3, 31, 12, 30, 30);
        press(OP_MONTH_DN);
        load(2000, 3, 30, 0, 0, 0);
        press(OP_MONTH_DN);
        load(2024, 2, 29, 1, 2, 3);
        press(OP_YEAR_UP);
        load(YEAR_MAX, MONTH_MAX, DAYS_LONG, HOUR_MAX, MIN_MAX, SEC_MAX);
        press(OP_YEAR_UP);
        press(OP_MONTH_UP);
        wait_drained();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) gap_odds = $urandom_range(0, 3);
            if (!calm_tail && n >= RANDOM_ITEMS - CALM_ITEMS) calm_tail <= 1'b1;
            else if (!calm_tail && $urandom_range(0, 19) == 0) wait_drained();

            it    = press_t'($urandom());
            it.op = OP_LOAD;
            wild  = ($urandom_range(0, 7) == 0);
            r     = $urandom_range(0, 9);
            if (r < 4) it.year = EDGE_YEARS[$urandom_range(0, $size(EDGE_YEARS) - 1)];
            else if (r < 9 || !wild) it.year = $urandom_range(0, YEAR_MAX);
            else it.year = $urandom();
            if (wild) begin
                it.month = $urandom();
            end else if ($urandom_range(0, 3) == 0) begin
                it.month = MONTH_FEB;
            end else begin
                it.month = $urandom_range(MONTH_FIRST, MONTH_MAX);
            end
            if (!wild) begin
                it.day    = $urandom_range(DAY_FIRST, DAYS_LONG);
                it.hour   = $urandom_range(0, HOUR_MAX);
                it.minute = $urandom_range(0, MIN_MAX);
                it.second = $urandom_range(0, SEC_MAX);
            end
            send_item(it);
            n++;

            run_len = $urandom_range(4, 24);
            repeat (run_len) begin
                it = press_t'($urandom());
                it.year = $urandom();
                r = $urandom_range(0, 99);
                if (r < 3) it.op = $urandom_range(OP_LOAD + 1, OP_CODES - 1);
                else if (r < 6) it.op = OP_LOAD;
                else it.op = $urandom_range(OP_YEAR_UP, OP_SEC_DN);
                send_item(it);
                n++;
            end
        end

        i_valid <= 1'b0;
        calm_tail <= 1'b1;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
